// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    `ASSERT_HOLDS(label, (ante) |-> (cons), msg)

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_HOLDS(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/dsv_pkg.sv =====
// Types, constants and sequencer encodings for the DSA sign/verify unit.
package dsv_pkg;

    localparam int MOD_BITS = 32;
    localparam int CNT_W    = $clog2(MOD_BITS);
    localparam int ADDR_W   = 5;

    typedef logic [MOD_BITS-1:0] word_t;

    // Operation codes of the input word
    localparam logic OP_SIGN   = 1'b0;
    localparam logic OP_VERIFY = 1'b1;

    // Configuration register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_P    = 3'd0,
        REG_Q    = 3'd1,
        REG_G    = 3'd2,
        REG_PRIV = 3'd3,
        REG_PUB  = 3'd4
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GOT_RED,
        ST_GOT_K,
        ST_GOT_KINV,
        ST_GOT_GP_S,
        ST_GOT_T,
        ST_GOT_R,
        ST_GOT_AQ,
        ST_GOT_AR,
        ST_GOT_S,
        ST_GOT_W,
        ST_GOT_U1,
        ST_GOT_U2,
        ST_GOT_GP_V,
        ST_GOT_X1,
        ST_GOT_AP,
        ST_GOT_X2,
        ST_GOT_V,
        ST_GOT_VQ,
        ST_LAUNCH,
        ST_MUL,
        ST_POW_SQ_GO,
        ST_POW_SQ,
        ST_POW_ML_GO,
        ST_POW_ML,
        ST_POW_NEXT,
        ST_DONE
    } st_t;

    typedef enum logic {
        EX_MUL,
        EX_POW
    } ex_kind_t;

    // One queued operation: mul(a, b) mod m or pow(a, b) mod m
    typedef struct packed {
        ex_kind_t kind;
        word_t    a;
        word_t    b;
        word_t    m;
        st_t      ret;
    } op_t;

    // Request into the modular multiplier
    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
        word_t m;
    } mm_req_t;

    // Status out of the modular multiplier
    typedef struct packed {
        logic  busy;
        logic  done;
        word_t product;
    } mm_stat_t;

endpackage

// ===== rtl/core/dsv_ifs.sv =====
// Valid/ready channel interfaces for request and response words.
interface dsv_in_if;
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [dsv_pkg::MOD_BITS-1:0] message;
    logic [dsv_pkg::MOD_BITS-1:0] nonce;
    logic [dsv_pkg::MOD_BITS-1:0] sig_r;
    logic [dsv_pkg::MOD_BITS-1:0] sig_s;

    modport source (output valid, opcode, message, nonce, sig_r, sig_s, input ready);
    modport sink (input valid, opcode, message, nonce, sig_r, sig_s, output ready);
endinterface

interface dsv_out_if;
    logic                   valid;
    logic                   ready;
    logic [dsv_pkg::MOD_BITS-1:0] reduced_message;
    logic [dsv_pkg::MOD_BITS-1:0] out_r;
    logic [dsv_pkg::MOD_BITS-1:0] out_s;
    logic                   valid_res;
    logic                   nonce_error;

    modport source (output valid, reduced_message, out_r, out_s, valid_res, nonce_error,
                    input ready);
    modport sink (input valid, reduced_message, out_r, out_s, valid_res, nonce_error,
                  output ready);
endinterface

// ===== rtl/core/dsv_modmul.sv =====
// Bit-serial modular multiplier: one double-and-add step per cycle.
`include "assert_macros.svh"

module dsv_modmul (
    input  logic              clk,
    input  logic              rst_n,
    input  dsv_pkg::mm_req_t  req,
    output dsv_pkg::mm_stat_t stat
);
    import dsv_pkg::*;

    word_t            a_reg, a_next;
    word_t            b_reg, b_next;
    word_t            m_reg, m_next;
    word_t            acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [MOD_BITS:0] dbl;
    logic [MOD_BITS:0] dbl_red;
    logic [MOD_BITS:0] sum;
    logic [MOD_BITS:0] sum_red;

    // Double the accumulator, then add a when the current bit of b is set
    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        sum     = dbl_red + {1'b0, a_reg};
        sum_red = (sum >= {1'b0, m_reg}) ? sum - {1'b0, m_reg} : sum;
    end

    // Sequence the steps from the top bit of b down
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            m_next    = req.m;
            acc_next  = '0;
            cnt_next  = CNT_W'(MOD_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = b_reg[cnt_reg] ? sum_red[MOD_BITS-1:0] : dbl_red[MOD_BITS-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
    end

    assign stat.busy    = busy_reg;
    assign stat.done    = done_reg;
    assign stat.product = acc_reg;

    `ASSERT_NEXT(a_start_busy, req.start, busy_reg, "multiplier did not start")
    `ASSERT_IMPLIES(a_prod_reduced, done_reg, acc_reg < m_reg, "product not reduced")

endmodule

// ===== rtl/core/dsa_sign_verify_unit.sv =====
// DSA sign/verify engine: sequencer around one shared modular multiplier.
//
// Usage: a request word on req carries an opcode (sign or verify), the message,
// the nonce k and the signature pair r, s. Each accepted word yields exactly one
// response word on rsp: message mod q, r and s (sign), a verify flag and an error
// flag for a zero nonce or, on sign, a modulus below 2. Domain values p, q, g, a
// and A are set over the APB port at byte addresses 0, 4, 8, 12, 16; the user must
// write them only while the unit is idle, as the block does not enforce this.
// One word is worked on at a time; req.ready is high only while idle.
// All products run on the bit-serial multiplier. Each exponentiation is 32
// squarings plus one product per set exponent bit; sign runs two exponentiations
// and seven products, verify runs three exponentiations and seven products.
// Early exits (zero nonce, signature out of range, modulus below 2) skip the
// remaining operations.
// The response sits in an output register until rsp.ready; a stalled receiver
// holds the unit in its done state. Reset clears the sequencer and the output
// valid and loads p = 3, q = 2, g = 1, a = 1, A = 1.
`include "assert_macros.svh"

module dsa_sign_verify_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    dsv_in_if.sink                     req,
    dsv_out_if.source                  rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dsv_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import dsv_pkg::*;

    localparam word_t ONE = word_t'(1);
    localparam word_t TWO = word_t'(2);

    // Configuration registers
    word_t p_reg, q_reg, g_reg, priv_reg, pub_reg;
    reg_idx_t cfg_idx;

    // Sequencer and working registers
    st_t              state_reg, state_next;
    op_t              op_reg, op_next;
    word_t            res_reg, res_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             verify_reg, verify_next;
    word_t            msg_reg, msg_next;
    word_t            nonce_reg, nonce_next;
    word_t            sr_reg, sr_next;
    word_t            ss_reg, ss_next;
    word_t            red_reg, red_next;
    word_t            k_reg, k_next;
    word_t            inv_reg, inv_next;
    word_t            orr_reg, orr_next;
    word_t            oss_reg, oss_next;
    word_t            u2_reg, u2_next;
    word_t            x1_reg, x1_next;
    logic             vld_reg, vld_next;
    logic             nerr_reg, nerr_next;

    // Output register
    logic  rsp_valid_reg, rsp_valid_next;
    word_t rsp_red_reg, rsp_red_next;
    word_t rsp_r_reg, rsp_r_next;
    word_t rsp_s_reg, rsp_s_next;
    logic  rsp_vld_reg, rsp_vld_next;
    logic  rsp_nerr_reg, rsp_nerr_next;

    mm_req_t  mm_req;
    mm_stat_t mm_stat;

    logic              bad_mod;
    logic              sig_ok;
    logic              out_free;
    logic [MOD_BITS:0] sum_w;
    word_t             sum_mod;

    dsv_modmul u_modmul (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (mm_req),
        .stat (mm_stat)
    );

    // Configuration port
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg    <= word_t'(3);
            q_reg    <= TWO;
            g_reg    <= ONE;
            priv_reg <= ONE;
            pub_reg  <= ONE;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (cfg_idx)
                REG_P:    p_reg    <= pwdata;
                REG_Q:    q_reg    <= pwdata;
                REG_G:    g_reg    <= pwdata;
                REG_PRIV: priv_reg <= pwdata;
                REG_PUB:  pub_reg  <= pwdata;
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_P:    prdata = p_reg;
            REG_Q:    prdata = q_reg;
            REG_G:    prdata = g_reg;
            REG_PRIV: prdata = priv_reg;
            REG_PUB:  prdata = pub_reg;
            default:  prdata = '0;
        endcase
    end

    // Shared conditions
    assign bad_mod  = (p_reg < TWO) || (q_reg < TWO);
    assign sig_ok   = (sr_reg != '0) && (sr_reg < q_reg) && (ss_reg != '0) && (ss_reg < q_reg);
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign sum_w    = {1'b0, red_reg} + {1'b0, res_reg};
    assign sum_mod  = (sum_w >= {1'b0, q_reg}) ? word_t'(sum_w - {1'b0, q_reg})
                                               : sum_w[MOD_BITS-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (req.valid) state_next = ST_CHECK;
            ST_CHECK:     state_next = bad_mod ? ST_DONE : ST_LAUNCH;
            ST_GOT_RED:   state_next = (verify_reg && !sig_ok) ? ST_DONE : ST_LAUNCH;
            ST_GOT_K:     state_next = (res_reg == '0) ? ST_DONE : ST_LAUNCH;
            ST_GOT_S:     state_next = ST_DONE;
            ST_GOT_VQ:    state_next = ST_DONE;
            ST_GOT_KINV, ST_GOT_GP_S, ST_GOT_T, ST_GOT_R, ST_GOT_AQ, ST_GOT_AR,
            ST_GOT_W, ST_GOT_U1, ST_GOT_U2, ST_GOT_GP_V, ST_GOT_X1, ST_GOT_AP,
            ST_GOT_X2, ST_GOT_V:
                          state_next = ST_LAUNCH;
            ST_LAUNCH:    state_next = (op_reg.kind == EX_MUL) ? ST_MUL : ST_POW_SQ_GO;
            ST_MUL:       if (mm_stat.done) state_next = op_reg.ret;
            ST_POW_SQ_GO: state_next = ST_POW_SQ;
            ST_POW_SQ:
            begin
                if (mm_stat.done)
                    state_next = op_reg.b[cnt_reg] ? ST_POW_ML_GO : ST_POW_NEXT;
            end
            ST_POW_ML_GO: state_next = ST_POW_ML;
            ST_POW_ML:    if (mm_stat.done) state_next = ST_POW_NEXT;
            ST_POW_NEXT:  state_next = (cnt_reg == '0) ? op_reg.ret : ST_POW_SQ_GO;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath and multiplier requests
    always_comb
    begin
        op_next     = op_reg;
        res_next    = res_reg;
        cnt_next    = cnt_reg;
        verify_next = verify_reg;
        msg_next    = msg_reg;
        nonce_next  = nonce_reg;
        sr_next     = sr_reg;
        ss_next     = ss_reg;
        red_next    = red_reg;
        k_next      = k_reg;
        inv_next    = inv_reg;
        orr_next    = orr_reg;
        oss_next    = oss_reg;
        u2_next     = u2_reg;
        x1_next     = x1_reg;
        vld_next    = vld_reg;
        nerr_next   = nerr_reg;

        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_red_next   = rsp_red_reg;
        rsp_r_next     = rsp_r_reg;
        rsp_s_next     = rsp_s_reg;
        rsp_vld_next   = rsp_vld_reg;
        rsp_nerr_next  = rsp_nerr_reg;

        mm_req.start = 1'b0;
        mm_req.a     = res_reg;
        mm_req.b     = res_reg;
        mm_req.m     = op_reg.m;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    verify_next = (req.opcode == OP_VERIFY);
                    msg_next    = req.message;
                    nonce_next  = req.nonce;
                    sr_next     = req.sig_r;
                    ss_next     = req.sig_s;
                    red_next    = '0;
                    orr_next    = '0;
                    oss_next    = '0;
                    vld_next    = 1'b0;
                    nerr_next   = 1'b0;
                end
            end
            ST_CHECK:
            begin
                if (bad_mod)
                    nerr_next = !verify_reg;
                else
                    op_next = '{EX_MUL, ONE, msg_reg, q_reg, ST_GOT_RED};
            end
            ST_GOT_RED:
            begin
                red_next = res_reg;
                if (!verify_reg)
                    op_next = '{EX_MUL, ONE, nonce_reg, q_reg, ST_GOT_K};
                else
                    op_next = '{EX_POW, ss_reg, q_reg - TWO, q_reg, ST_GOT_W};
            end
            ST_GOT_K:
            begin
                k_next = res_reg;
                if (res_reg == '0)
                    nerr_next = 1'b1;
                else
                    op_next = '{EX_POW, res_reg, q_reg - TWO, q_reg, ST_GOT_KINV};
            end
            ST_GOT_KINV:
            begin
                inv_next = res_reg;
                op_next  = '{EX_MUL, ONE, g_reg, p_reg, ST_GOT_GP_S};
            end
            ST_GOT_GP_S: op_next = '{EX_POW, res_reg, k_reg, p_reg, ST_GOT_T};
            ST_GOT_T:    op_next = '{EX_MUL, ONE, res_reg, q_reg, ST_GOT_R};
            ST_GOT_R:
            begin
                orr_next = res_reg;
                op_next  = '{EX_MUL, ONE, priv_reg, q_reg, ST_GOT_AQ};
            end
            ST_GOT_AQ:   op_next = '{EX_MUL, res_reg, orr_reg, q_reg, ST_GOT_AR};
            ST_GOT_AR:   op_next = '{EX_MUL, sum_mod, inv_reg, q_reg, ST_GOT_S};
            ST_GOT_S:    oss_next = res_reg;
            ST_GOT_W:
            begin
                inv_next = res_reg;
                op_next  = '{EX_MUL, red_reg, res_reg, q_reg, ST_GOT_U1};
            end
            ST_GOT_U1:
            begin
                k_next  = res_reg;
                op_next = '{EX_MUL, sr_reg, inv_reg, q_reg, ST_GOT_U2};
            end
            ST_GOT_U2:
            begin
                u2_next = res_reg;
                op_next = '{EX_MUL, ONE, g_reg, p_reg, ST_GOT_GP_V};
            end
            ST_GOT_GP_V: op_next = '{EX_POW, res_reg, k_reg, p_reg, ST_GOT_X1};
            ST_GOT_X1:
            begin
                x1_next = res_reg;
                op_next = '{EX_MUL, ONE, pub_reg, p_reg, ST_GOT_AP};
            end
            ST_GOT_AP:   op_next = '{EX_POW, res_reg, u2_reg, p_reg, ST_GOT_X2};
            ST_GOT_X2:   op_next = '{EX_MUL, x1_reg, res_reg, p_reg, ST_GOT_V};
            ST_GOT_V:    op_next = '{EX_MUL, ONE, res_reg, q_reg, ST_GOT_VQ};
            ST_GOT_VQ:   vld_next = (res_reg == sr_reg);
            ST_LAUNCH:
            begin
                if (op_reg.kind == EX_MUL)
                begin
                    mm_req.start = 1'b1;
                    mm_req.a     = op_reg.a;
                    mm_req.b     = op_reg.b;
                end
                else
                begin
                    res_next = ONE;
                    cnt_next = CNT_W'(MOD_BITS - 1);
                end
            end
            ST_MUL, ST_POW_SQ, ST_POW_ML:
            begin
                if (mm_stat.done)
                    res_next = mm_stat.product;
            end
            ST_POW_SQ_GO: mm_req.start = 1'b1;
            ST_POW_ML_GO:
            begin
                mm_req.start = 1'b1;
                mm_req.b     = op_reg.a;
            end
            ST_POW_NEXT:
            begin
                if (cnt_reg != '0)
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_red_next   = red_reg;
                    rsp_r_next     = orr_reg;
                    rsp_s_next     = oss_reg;
                    rsp_vld_next   = vld_reg;
                    rsp_nerr_next  = nerr_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        res_reg      <= res_next;
        cnt_reg      <= cnt_next;
        verify_reg   <= verify_next;
        msg_reg      <= msg_next;
        nonce_reg    <= nonce_next;
        sr_reg       <= sr_next;
        ss_reg       <= ss_next;
        red_reg      <= red_next;
        k_reg        <= k_next;
        inv_reg      <= inv_next;
        orr_reg      <= orr_next;
        oss_reg      <= oss_next;
        u2_reg       <= u2_next;
        x1_reg       <= x1_next;
        vld_reg      <= vld_next;
        nerr_reg     <= nerr_next;
        rsp_red_reg  <= rsp_red_next;
        rsp_r_reg    <= rsp_r_next;
        rsp_s_reg    <= rsp_s_next;
        rsp_vld_reg  <= rsp_vld_next;
        rsp_nerr_reg <= rsp_nerr_next;
    end

    // Channel outputs
    assign req.ready           = (state_reg == ST_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.reduced_message = rsp_red_reg;
    assign rsp.out_r           = rsp_r_reg;
    assign rsp.out_s           = rsp_s_reg;
    assign rsp.valid_res       = rsp_vld_reg;
    assign rsp.nonce_error     = rsp_nerr_reg;

    `ASSERT_IMPLIES(a_mul_active,
        (state_reg == ST_MUL) || (state_reg == ST_POW_SQ) || (state_reg == ST_POW_ML),
        mm_stat.busy || mm_stat.done, "waiting on an idle multiplier")
    `ASSERT_IMPLIES(a_nerr_zero_sig, rsp.valid && rsp.nonce_error,
        (rsp.out_r == '0) && (rsp.out_s == '0), "signature given with nonce error")
    `ASSERT_IMPLIES(a_flags_exclusive, rsp.valid,
        !(rsp.valid_res && rsp.nonce_error), "verify and nonce flags both set")

endmodule
